### rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Types and constants shared by the keyed counter table and its cells.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;
    localparam int KEY_W   = 31;
    localparam int COUNT_W = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0]
    {
        MODE_ADD = 2'd0,
        MODE_GET = 2'd1,
        MODE_SET = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_NEG    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef struct packed
    {
        mode_t               mode;
        logic [KEY_W-1:0]    key;
        logic [COUNT_W-1:0]  cnt;
    } op_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } res_t;

endpackage

### rtl/kct_cell.sv
// ----------------------------------------------------------------------------
// kct_cell
// One table entry. Resolves the operation passing by when the key matches or
// the entry is free, otherwise registers it and hands it to the next cell.
// ----------------------------------------------------------------------------
module kct_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid_in,
    input  kct_pkg::op_t   op_in,
    output logic           op_valid_out,
    output kct_pkg::op_t   op_out,
    output logic           done,
    output kct_pkg::res_t  res,
    output logic           entry_valid
);
    import kct_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                pass_reg;
    logic                pass_next;
    op_t                 op_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        pass_next  = 1'b0;
        done       = 1'b0;
        res.count  = '0;
        res.status = ST_OK;
        if (op_valid_in)
        begin
            if (valid_reg && key_reg == op_in.key)
            begin
                done = 1'b1;
                unique case (op_in.mode)
                    MODE_ADD:
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        res.count = count_next;
                    end
                    MODE_GET: res.count = count_reg;
                    MODE_SET: count_next = op_in.cnt;
                    default:  res.status = ST_OK;
                endcase
            end
            else if (!valid_reg)
            begin
                // valid entries form a prefix, so the key lives nowhere further on
                done = 1'b1;
                unique case (op_in.mode)
                    MODE_ADD:
                    begin
                        valid_next = 1'b1;
                        key_next   = op_in.key;
                        count_next = COUNT_W'(1);
                        res.count  = COUNT_W'(1);
                    end
                    MODE_GET: res.status = ST_ABSENT;
                    MODE_SET:
                    begin
                        valid_next = 1'b1;
                        key_next   = op_in.key;
                        count_next = op_in.cnt;
                    end
                    default:  res.status = ST_OK;
                endcase
            end
            else
            begin
                pass_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
        op_reg    <= op_in;
    end

    assign op_valid_out = pass_reg;
    assign op_out       = op_reg;
    assign entry_valid  = valid_reg;

endmodule

### rtl/keyed_counter_table.sv
// ----------------------------------------------------------------------------
// keyed_counter_table
// Bounded associative table of saturating counters held in a row of cells.
// ----------------------------------------------------------------------------
// input beat: mode, key, new_count on in_valid/in_ready
// output beat: count_out, status on out_valid/out_ready, one per input beat
// an operation enters cell 0 and walks one cell per cycle until it meets its
// key or the first free entry; entries fill from cell 0 upwards and are never
// removed, so the first free cell ends the search
// a result goes from the resolving cell, or from the end of the row when the
// table is full or the key is absent, into the done register and then the
// output register; a negative operand or mode 3 skips the row and goes straight to the done register
// one operation is in the row at a time: the next beat is taken only once
// the result has moved on from the done register to the output register
// reset empties the table at once; no clearing pass
// a stalled receiver holds the output beat; one more input beat may still be
// taken and worked, its result waiting until the output register frees
// ----------------------------------------------------------------------------
module keyed_counter_table
#(
    parameter int TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] new_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        count_out,
    output logic [1:0]         status
);
    import kct_pkg::*;

    logic                      op_valid_reg;
    logic                      op_valid_next;
    op_t                       op_reg;
    op_t                       op_next;
    logic                      done_valid_reg;
    logic                      done_valid_next;
    res_t                      done_res_reg;
    res_t                      done_res_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    res_t                      out_res_reg;

    logic [TABLE_ENTRIES-1:0]  link_valid;
    op_t                       link_op [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  cell_done;
    res_t                      cell_res [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  entry_vld;
    res_t                      cell_merged;

    logic                      accept;
    logic                      negative;
    logic                      trivial;
    logic                      out_load;
    mode_t                     in_mode;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                kct_cell u_cell
                (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .op_valid_in  (op_valid_reg),
                    .op_in        (op_reg),
                    .op_valid_out (link_valid[gi]),
                    .op_out       (link_op[gi]),
                    .done         (cell_done[gi]),
                    .res          (cell_res[gi]),
                    .entry_valid  (entry_vld[gi])
                );
            end
            else
            begin : g_body
                kct_cell u_cell
                (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .op_valid_in  (link_valid[gi-1]),
                    .op_in        (link_op[gi-1]),
                    .op_valid_out (link_valid[gi]),
                    .op_out       (link_op[gi]),
                    .done         (cell_done[gi]),
                    .res          (cell_res[gi]),
                    .entry_valid  (entry_vld[gi])
                );
            end
        end
    endgenerate

    assign in_mode  = mode_t'(mode);
    assign negative = (in_mode != MODE_NOP && key[31]) ||
                      (in_mode == MODE_SET && new_count[31]);
    assign trivial  = negative || in_mode == MODE_NOP;
    assign in_ready = !op_valid_reg && (link_valid == '0) && !done_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_load = done_valid_reg && (!out_valid_reg || out_ready);

    // only one cell can finish in a cycle
    always_comb
    begin
        cell_merged = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cell_merged = res_t'(cell_merged | (cell_res[i] & {$bits(res_t){cell_done[i]}}));
        end
    end

    always_comb
    begin
        op_valid_next   = 1'b0;
        op_next         = op_reg;
        done_valid_next = done_valid_reg;
        done_res_next   = done_res_reg;
        if (out_load)
        begin
            done_valid_next = 1'b0;
        end
        if (accept)
        begin
            op_next.mode = in_mode;
            op_next.key  = key[30:0];
            op_next.cnt  = new_count[30:0];
            if (trivial)
            begin
                done_valid_next      = 1'b1;
                done_res_next.count  = '0;
                done_res_next.status = negative ? ST_NEG : ST_OK;
            end
            else
            begin
                op_valid_next = 1'b1;
            end
        end
        else if (cell_done != '0)
        begin
            done_valid_next = 1'b1;
            done_res_next   = cell_merged;
        end
        else if (link_valid[TABLE_ENTRIES-1])
        begin
            // walked off the end of the row
            done_valid_next      = 1'b1;
            done_res_next.count  = '0;
            done_res_next.status = (link_op[TABLE_ENTRIES-1].mode == MODE_GET) ?
                                   ST_ABSENT : ST_FULL;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg   <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            op_valid_reg   <= op_valid_next;
            done_valid_reg <= done_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        done_res_reg <= done_res_next;
        if (out_load)
        begin
            out_res_reg <= done_res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign count_out = out_res_reg.count;
    assign status    = out_res_reg.status;

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({link_valid, op_valid_reg, done_valid_reg}))
        else $error("more than one operation in flight");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!op_valid_reg && link_valid == '0 && cell_done == '0))
        else $error("input ready while the row is busy");

    a_prefix_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ((entry_vld >> 1) & ~entry_vld) == '0)
        else $error("table entries not filled from the bottom");

    a_inject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !trivial) |=> (op_valid_reg && !done_valid_reg))
        else $error("accepted beat did not enter the row");

endmodule
